>>> sv/rlss_pkg.sv
// ----------------------------------------------------------------------------
// rlss_pkg
// Shared widths, opcodes and frame constants of the RGB LED serializer.
// ----------------------------------------------------------------------------
package rlss_pkg;

	localparam int MAX_LEDS  = 64;
	localparam int LED_AW    = $clog2(MAX_LEDS);

	localparam int OP_W      = 2;
	localparam int INDEX_W   = 6;
	localparam int CHAN_W    = 12;
	localparam int COLOUR_W  = 3 * CHAN_W;
	localparam int COUNT_W   = 7;
	localparam int BIT_W     = 4;
	localparam int GAP_W     = 4;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_START = 2'd2
	} opcode_t;

	localparam logic [CHAN_W-1:0] HEADER_WORD = 12'h3AA;
	localparam logic [BIT_W-1:0]  WORD_LAST   = 4'd11;
	localparam logic [GAP_W-1:0]  GAP_TICKS   = 4'd4;
	localparam logic [GAP_W-1:0]  LATCH_TICKS = 4'd8;

endpackage

>>> sv/rlss_cmd_if.sv
// ----------------------------------------------------------------------------
// rlss_cmd_if
// Command channel: tick, colour write and frame start items.
// ----------------------------------------------------------------------------
interface rlss_cmd_if;
	import rlss_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [INDEX_W-1:0]  led_index;
	logic [CHAN_W-1:0]   red;
	logic [CHAN_W-1:0]   green;
	logic [CHAN_W-1:0]   blue;

	modport source (output valid, opcode, led_index, red, green, blue, input ready);
	modport sink   (input valid, opcode, led_index, red, green, blue, output ready);

endinterface

>>> sv/rlss_res_if.sv
// ----------------------------------------------------------------------------
// rlss_res_if
// Result channel: one line symbol per tick item.
// ----------------------------------------------------------------------------
interface rlss_res_if;

	logic valid;
	logic ready;
	logic lead_pulse;
	logic data_pulse;
	logic frame_busy;

	modport source (output valid, lead_pulse, data_pulse, frame_busy, input ready);
	modport sink   (input valid, lead_pulse, data_pulse, frame_busy, output ready);

endinterface

>>> sv/rgb_led_single_wire_serializer.sv
// ----------------------------------------------------------------------------
// rgb_led_single_wire_serializer
// Frame serializer for chained single-wire RGB LEDs with a colour store.
// ----------------------------------------------------------------------------
// The block takes one command item per clock unless a tick waits for a
// result not yet taken, and returns one result for each tick item, registered
// as the item leaves its input register. The rate is set by the single
// registered pass from the input register to the result register; the colour
// memory is read every clock at the current LED position with a registered
// read and a bypass for a write in the previous clock, so colour writes in the
// middle of a frame never stall ticks. The store reads as zero after reset
// through one valid flip-flop per entry, so there is no clearing pass. A frame
// sends the header 0x3AA and 12-bit red, green and blue values MSB first for
// each LED, 4 idle ticks between LEDs and 8 latch ticks at the end; starts
// during a frame are dropped. Write led_count only while no item is pending.
module rgb_led_single_wire_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	rlss_cmd_if.sink            cmd,
	rlss_res_if.source          res
);
	import rlss_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER, PH_RED, PH_GREEN, PH_BLUE, PH_GAP, PH_LATCH, PH_DONE
	} phase_t;

	// Configuration register.
	logic [COUNT_W-1:0] led_count_q;
	logic               cfg_sel;

	assign cfg_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = cfg_sel ? 32'(led_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= COUNT_W'(1);
		end else if (psel && penable && pwrite && cfg_sel) begin
			led_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// Input register.
	logic                s1_valid;
	opcode_t             op_s1;
	logic [INDEX_W-1:0]  index_s1;
	logic [COLOUR_W-1:0] colour_s1;
	logic                s1_adv;
	logic                out_valid_q;

	assign s1_adv    = s1_valid && ((op_s1 != OP_TICK) || !out_valid_q || res.ready);
	assign cmd.ready = !s1_valid || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1     <= opcode_t'(cmd.opcode);
			index_s1  <= cmd.led_index;
			colour_s1 <= {cmd.red, cmd.green, cmd.blue};
		end
	end

	// Frame state.
	phase_t             phase_q, phase_d;
	logic [BIT_W-1:0]   bit_q, bit_d;
	logic [LED_AW-1:0]  led_pos_q, led_pos_d;
	logic [GAP_W-1:0]   gap_q, gap_d;
	logic [CHAN_W-1:0]  shift_q, shift_d;
	logic               lead_q, data_q, busy_q;
	logic               lead_d, data_d;

	// Colour store.
	logic [COLOUR_W-1:0] mem [MAX_LEDS];
	logic [MAX_LEDS-1:0] vld_q;
	logic [COLOUR_W-1:0] rd_q, wdata_q, colour;
	logic                rd_vld_q, hit_q;
	logic                wr_en;
	logic [LED_AW-1:0]   wr_addr;

	assign wr_en   = s1_adv && (op_s1 == OP_WRITE) && (32'(index_s1) < MAX_LEDS);
	assign wr_addr = LED_AW'(index_s1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= colour_s1;
		end
		rd_q    <= mem[led_pos_d];
		wdata_q <= colour_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[led_pos_d];
			// The memory read above misses a write at the same edge.
			hit_q    <= wr_en && (wr_addr == led_pos_d);
		end
	end

	assign colour = hit_q ? wdata_q : (rd_vld_q ? rd_q : '0);

	// Effective LED count, clamped to one .. MAX_LEDS.
	logic [LED_AW:0] eff_count;
	logic            last_led;

	always_comb begin
		if (led_count_q == '0) begin
			eff_count = (LED_AW+1)'(1);
		end else if (32'(led_count_q) > MAX_LEDS) begin
			eff_count = (LED_AW+1)'(MAX_LEDS);
		end else begin
			eff_count = (LED_AW+1)'(led_count_q);
		end
	end

	assign last_led = (({1'b0, led_pos_q} + (LED_AW+1)'(1)) >= eff_count);

	logic [CHAN_W-1:0] word;

	always_comb begin
		case (phase_q)
			PH_RED:   word = colour[3*CHAN_W-1:2*CHAN_W];
			PH_GREEN: word = colour[2*CHAN_W-1:CHAN_W];
			PH_BLUE:  word = colour[CHAN_W-1:0];
			default:  word = HEADER_WORD;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		bit_d     = bit_q;
		led_pos_d = led_pos_q;
		gap_d     = gap_q;
		shift_d   = shift_q;
		lead_d    = 1'b0;
		data_d    = 1'b0;
		if (s1_adv && (op_s1 == OP_START) && (phase_q == PH_DONE)) begin
			phase_d   = PH_HEADER;
			bit_d     = '0;
			led_pos_d = '0;
			gap_d     = '0;
			shift_d   = '0;
		end else if (s1_adv && (op_s1 == OP_TICK)) begin
			unique case (phase_q)
				PH_HEADER, PH_RED, PH_GREEN, PH_BLUE: begin
					lead_d = 1'b1;
					if (bit_q == '0) begin
						shift_d = word;
						data_d  = word[CHAN_W-1];
					end else begin
						data_d  = shift_q[WORD_LAST - bit_q];
					end
					if (bit_q == WORD_LAST) begin
						bit_d = '0;
						if (phase_q != PH_BLUE) begin
							phase_d = phase_t'(phase_q + 3'd1);
						end else if (last_led) begin
							gap_d   = LATCH_TICKS;
							phase_d = PH_LATCH;
						end else begin
							gap_d   = GAP_TICKS;
							phase_d = PH_GAP;
						end
					end else begin
						bit_d = bit_q + BIT_W'(1);
					end
				end
				PH_GAP: begin
					gap_d = gap_q - GAP_W'(1);
					if (gap_d == '0) begin
						led_pos_d = led_pos_q + LED_AW'(1);
						phase_d   = PH_HEADER;
					end
				end
				PH_LATCH: begin
					gap_d = gap_q - GAP_W'(1);
					if (gap_d == '0) begin
						phase_d = PH_DONE;
					end
				end
				default: phase_d = PH_DONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DONE;
			bit_q       <= '0;
			led_pos_q   <= '0;
			gap_q       <= '0;
			shift_q     <= '0;
			out_valid_q <= 1'b0;
			lead_q      <= 1'b0;
			data_q      <= 1'b0;
			busy_q      <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			bit_q     <= bit_d;
			led_pos_q <= led_pos_d;
			gap_q     <= gap_d;
			shift_q   <= shift_d;
			if (s1_adv && (op_s1 == OP_TICK)) begin
				out_valid_q <= 1'b1;
				lead_q      <= lead_d;
				data_q      <= data_d;
				busy_q      <= (phase_d != PH_DONE);
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid      = out_valid_q;
	assign res.lead_pulse = lead_q;
	assign res.data_pulse = data_q;
	assign res.frame_busy = busy_q;

endmodule

>>> tb/rlss_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rlss_checker
// Watches the command, result and register channels of the LED serializer,
// keeps its own copy of the colour store and frame sequencer, and compares
// every result transfer with the oldest predicted line symbol.
// ----------------------------------------------------------------------------
module rlss_checker
	import rlss_pkg::*;
#(
	parameter logic [2:0] COUNT_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	rlss_cmd_if         cmd,
	rlss_res_if         res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);

	typedef enum logic [2:0] {
		PH_HEADER = 3'd1,
		PH_RED    = 3'd2,
		PH_GREEN  = 3'd3,
		PH_BLUE   = 3'd4,
		PH_GAP    = 3'd5,
		PH_LATCH  = 3'd6,
		PH_DONE   = 3'd7
	} frame_phase_t;

	typedef struct packed {
		logic lead;
		logic data;
		logic busy;
	} line_symbol_t;

	logic [COLOUR_W-1:0] colour_mem [MAX_LEDS];
	frame_phase_t        phase;
	logic [BIT_W-1:0]    bit_pos;
	logic [LED_AW-1:0]   led_pos;
	logic [GAP_W-1:0]    gap_cnt;
	logic [CHAN_W-1:0]   shift_reg;
	logic [COUNT_W-1:0]  chain_len;

	line_symbol_t expected_symbols [$];
	line_symbol_t got, want;
	int           mismatches;

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	function automatic int chain_eff();
		int n;
		n = chain_len;
		if (n == 0)
			n = 1;
		if (n > MAX_LEDS)
			n = MAX_LEDS;
		return n;
	endfunction

	function automatic logic [CHAN_W-1:0] word_now();
		logic [COLOUR_W-1:0] c;
		c = colour_mem[led_pos];
		case (phase)
			PH_HEADER: return HEADER_WORD;
			PH_RED:    return c[3*CHAN_W-1:2*CHAN_W];
			PH_GREEN:  return c[2*CHAN_W-1:CHAN_W];
			default:   return c[CHAN_W-1:0];
		endcase
	endfunction

	task automatic clear_state();
		for (int i = 0; i < MAX_LEDS; i++)
			colour_mem[i] = '0;
		phase     = PH_DONE;
		bit_pos   = '0;
		led_pos   = '0;
		gap_cnt   = '0;
		shift_reg = '0;
		chain_len = 7'd1;
	endtask

	// One tick moves the sequencer by one bit cycle and yields one symbol.
	task automatic serialize_tick();
		line_symbol_t sym;
		sym = '0;
		if (phase == PH_HEADER || phase == PH_RED || phase == PH_GREEN ||
				phase == PH_BLUE) begin
			if (bit_pos == 0)
				shift_reg = word_now();
			sym.lead = 1'b1;
			sym.data = shift_reg[WORD_LAST - bit_pos];
			if (bit_pos == WORD_LAST) begin
				bit_pos = '0;
				case (phase)
					PH_HEADER: phase = PH_RED;
					PH_RED:    phase = PH_GREEN;
					PH_GREEN:  phase = PH_BLUE;
					default: begin
						if (int'(led_pos) + 1 >= chain_eff()) begin
							gap_cnt = LATCH_TICKS;
							phase   = PH_LATCH;
						end else begin
							gap_cnt = GAP_TICKS;
							phase   = PH_GAP;
						end
					end
				endcase
			end else begin
				bit_pos = bit_pos + 1'b1;
			end
		end else if (phase == PH_GAP) begin
			gap_cnt = gap_cnt - 1'b1;
			if (gap_cnt == 0) begin
				led_pos = led_pos + 1'b1;
				phase   = PH_HEADER;
			end
		end else if (phase == PH_LATCH) begin
			gap_cnt = gap_cnt - 1'b1;
			if (gap_cnt == 0)
				phase = PH_DONE;
		end else begin
			phase = PH_DONE;
		end
		sym.busy = (phase != PH_DONE);
		expected_symbols.push_back(sym);
	endtask

	task automatic apply_command();
		case (cmd.opcode)
			OP_WRITE: colour_mem[cmd.led_index] = {cmd.red, cmd.green, cmd.blue};
			OP_START: begin
				if (phase == PH_DONE) begin
					phase     = PH_HEADER;
					bit_pos   = '0;
					led_pos   = '0;
					gap_cnt   = '0;
					shift_reg = '0;
				end
			end
			OP_TICK:  serialize_tick();
			default:  ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			expected_symbols.delete();
			mismatches = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// Results are taken first; a command accepted at this edge cannot
			// have produced one yet.
			if (res.valid && res.ready) begin
				got = {res.lead_pulse, res.data_pulse, res.frame_busy};
				if (expected_symbols.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_symbols.pop_front();
					if (got.lead !== want.lead)
						report_mismatch($sformatf("lead_pulse %b, expected %b",
							got.lead, want.lead));
					if (got.data !== want.data)
						report_mismatch($sformatf("data_pulse %b, expected %b",
							got.data, want.data));
					if (got.busy !== want.busy)
						report_mismatch($sformatf("frame_busy %b, expected %b",
							got.busy, want.busy));
				end
			end
			if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
				chain_len = pwdata[COUNT_W-1:0];
			if (cmd.valid && cmd.ready)
				apply_command();
			pending <= expected_symbols.size();
			errors  <= mismatches;
		end
	end

endmodule

>>> tb/rgb_led_single_wire_serializer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_led_single_wire_serializer_test
// Drives colour writes, frame starts and ticks into the LED serializer under
// several chain lengths and idling profiles; a checker beside the block
// predicts every line symbol and counts mismatches.
// ----------------------------------------------------------------------------
module rgb_led_single_wire_serializer_test;
	import rlss_pkg::*;

	localparam logic [2:0]      LED_COUNT_ADDR = 3'd0;
	localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
	localparam int HOLD_OFF      = 16;
	localparam int END_WAIT      = 20;
	localparam int IDLE_LIMIT    = 1000;
	localparam int PHASE_ITEMS   = 170;
	localparam int RANDOM_PHASES = 6;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int err_count;
	int pending_count;
	int send_idle_pct;
	int recv_stall_pct;
	int idle_cycles;
	int phase_items;

	int chain_choices [8] = '{1, 2, 3, 0, 2, 4, 1, 5};

	rlss_cmd_if cmd_ch ();
	rlss_res_if res_ch ();

	rgb_led_single_wire_serializer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_ch),
		.res     (res_ch)
	);

	rlss_checker #(
		.COUNT_ADDR (LED_COUNT_ADDR)
	) u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.errors  (err_count),
		.pending (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk)
		res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic set_profile(input int k);
		case (k % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
			default: begin send_idle_pct = 8; recv_stall_pct = 8; end
		endcase
	endtask

	function automatic int effective_chain(input int c);
		if (c == 0)
			return 1;
		if (c > MAX_LEDS)
			return MAX_LEDS;
		return c;
	endfunction

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return CHAN_W'($urandom_range(4095));
		endcase
	endfunction

	// Valid stays high from one transfer to the next unless a gap is drawn.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
			input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b);
		bit lowered;
		lowered = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			if (!lowered) begin
				cmd_ch.valid <= 1'b0;
				lowered = 1'b1;
			end
			@(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.opcode    <= op;
		cmd_ch.led_index <= idx;
		cmd_ch.red       <= r;
		cmd_ch.green     <= g;
		cmd_ch.blue      <= b;
		do @(posedge clk); while (!cmd_ch.ready);
		phase_items++;
	endtask

	task automatic send_op(input logic [OP_W-1:0] op);
		send_item(op, INDEX_W'($urandom_range(63)), rand_chan(), rand_chan(), rand_chan());
	endtask

	task automatic send_random_write(input int span);
		logic [INDEX_W-1:0] idx;
		if ($urandom_range(1))
			idx = INDEX_W'($urandom_range(63));
		else
			idx = INDEX_W'($urandom_range(span - 1));
		send_item(OP_WRITE, idx, rand_chan(), rand_chan(), rand_chan());
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	// Only the low seven bits hold the count; the rest carry noise.
	task automatic set_chain_len(input logic [COUNT_W-1:0] n);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= LED_COUNT_ADDR;
		pwdata  <= ($urandom & ~32'h7F) | 32'(n);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// A start followed by enough ticks to finish a frame of the given length,
	// with colour writes, stray starts and unused opcodes mixed in.
	task automatic run_frame(input int leds, input int tail);
		int total;
		int pick;
		total = 52 * leds + 4 + tail;
		send_op(OP_START);
		for (int t = 0; t < total; t++) begin
			pick = $urandom_range(99);
			if (pick < 8)
				send_random_write(leds);
			else if (pick < 10)
				send_op(OP_START);
			else if (pick < 11)
				send_op(OP_UNUSED);
			send_op(OP_TICK);
		end
	endtask

	task automatic run_phase(input int chain, input int profile);
		drain();
		set_chain_len(COUNT_W'(chain));
		set_profile(profile);
		phase_items = 0;
		while (phase_items < PHASE_ITEMS) begin
			if ($urandom_range(99) < 85)
				run_frame(effective_chain(chain), $urandom_range(3));
			else
				repeat ($urandom_range(1, 6)) send_op(OP_W'($urandom_range(3)));
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.opcode    = OP_TICK;
		cmd_ch.led_index = '0;
		cmd_ch.red       = '0;
		cmd_ch.green     = '0;
		cmd_ch.blue      = '0;
		res_ch.ready     = 1'b0;
		idle_cycles      = 0;
		phase_items      = 0;
		set_profile(0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle tick, unused opcode, corner colours, start while busy.
		send_op(OP_TICK);
		send_op(OP_UNUSED);
		send_item(OP_WRITE, 6'd0, 12'hFFF, 12'hFFF, 12'hFFF);
		send_item(OP_WRITE, 6'd63, 12'hFFF, 12'hFFF, 12'hFFF);
		send_item(OP_WRITE, 6'd2, 12'h800, 12'h001, 12'hA5A);
		send_op(OP_START);
		send_op(OP_START);
		repeat (5) send_op(OP_TICK);
		// The red word of LED 0 is read only when its first bit goes out.
		send_item(OP_WRITE, 6'd0, 12'h000, 12'hFFF, 12'h000);
		repeat (55) send_op(OP_TICK);

		// A count of zero behaves as a single LED.
		drain();
		set_chain_len(7'd0);
		send_op(OP_START);
		repeat (58) send_op(OP_TICK);

		drain();
		set_chain_len(7'd3);
		send_op(OP_START);
		repeat (52 * 3 + 6) send_op(OP_TICK);

		for (int ph = 0; ph < RANDOM_PHASES; ph++)
			run_phase(chain_choices[ph % 8], ph);

		// A count above the chain limit acts as the full chain; the chain is
		// then shortened in the middle of the third LED.
		drain();
		set_chain_len(7'd127);
		set_profile(1);
		send_op(OP_START);
		repeat (52 * 2 + 10) send_op(OP_TICK);
		drain();
		set_chain_len(7'd2);
		set_profile(2);
		repeat (120) send_op(OP_TICK);

		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (END_WAIT) @(posedge clk);
		if (err_count == 0 && pending_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
